// ===== rtl/assert_macros.svh =====
// Assertion macros included by the framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define NRMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define NRMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define NRMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NRMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NRMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define NRMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/nrmc_pkg.sv =====
`default_nettype none

package nrmc_pkg;

    // ASCII codes used by the framer
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_R      = 8'd82;
    localparam logic [7:0] CH_M      = 8'd77;
    localparam logic [7:0] CH_C      = 8'd67;

    // printable range
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;

    // shortest sentence that can carry the RMC tag
    localparam int MIN_RMC_LEN = 6;

    // positions of the tag characters
    localparam int POS_R = 3;
    localparam int POS_M = 4;
    localparam int POS_C = 5;

    // sequencer states
    typedef enum logic [2:0] {
        S_COLLECT = 3'b001,
        S_LOAD    = 3'b010,
        S_EMIT    = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/nrmc_if.sv =====
`default_nettype none

// received byte channel
interface nrmc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// replayed sentence channel
interface nrmc_sent_if;
    logic       valid;
    logic       ready;
    logic [6:0] sentence_byte;
    logic       last_of_sentence;

    modport source (output valid, output sentence_byte, output last_of_sentence, input ready);
    modport sink   (input valid, input sentence_byte, input last_of_sentence, output ready);
endinterface

`default_nettype wire

// ===== rtl/nrmc_store.sv =====
`default_nettype none

// Sentence buffer: one write port, one read port, registered read data.
module nrmc_store #(
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [6:0]               wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [6:0]               rd_data
);

    logic [6:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nmea_rmc_sentence_framer.sv =====
// Channel   Modport  Payload                                Role
// rx        sink     rx_byte[7:0]                           bytes from the serial receiver
// sentence  source   sentence_byte[6:0], last_of_sentence   replayed RMC sentence
//
// Collecting: one byte per cycle; rx.ready is high whenever no replay runs.
// Replay: each character goes through a store read, then the output register,
// and the next read starts only when sentence.ready takes the current one.
// rx.ready stays low from the terminator until the last character is taken.
// Reset clears the control state only; the store holds no reset value and
// needs no clearing pass, since only entries written in the open sentence are read.
`default_nettype none
`include "assert_macros.svh"

module nmea_rmc_sentence_framer #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    nrmc_rx_if.sink       rx,
    nrmc_sent_if.source   sentence
);

    localparam int IDX_W = $clog2(BUFFER_BYTES);

    nrmc_pkg::state_t state_reg, state_next;

    logic             in_frame_reg, in_frame_next;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             r_ok_reg, r_ok_next;
    logic             m_ok_reg, m_ok_next;
    logic             c_ok_reg, c_ok_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [6:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [6:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [6:0]       rd_data;

    logic             rx_fire;
    logic             out_fire;
    logic             is_tag;
    logic             last_fire;
    logic             first_load;
    logic             dollar_out;

    nrmc_store #(
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rx.ready                  = (state_reg == nrmc_pkg::S_COLLECT);
    assign sentence.valid            = out_valid_reg;
    assign sentence.sentence_byte    = out_byte_reg;
    assign sentence.last_of_sentence = out_last_reg;

    assign rx_fire  = rx.valid && rx.ready;
    assign out_fire = out_valid_reg && sentence.ready;

    // complete RMC tag seen in the open sentence
    assign is_tag = (fill_reg >= IDX_W'(nrmc_pkg::MIN_RMC_LEN)) && r_ok_reg && m_ok_reg
                    && c_ok_reg;

    // framing and replay sequencer
    always_comb
    begin
        state_next     = state_reg;
        in_frame_next  = in_frame_reg;
        fill_next      = fill_reg;
        r_ok_next      = r_ok_reg;
        m_ok_next      = m_ok_reg;
        c_ok_next      = c_ok_reg;
        rd_idx_next    = rd_idx_reg;
        last_idx_next  = last_idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = fill_reg;
        wr_data        = rx.rx_byte[6:0];
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg;

        case (state_reg)
            nrmc_pkg::S_COLLECT:
            begin
                if (rx_fire)
                begin
                    if (rx.rx_byte == nrmc_pkg::CH_DOLLAR)
                    begin
                        // restart: '$' goes to entry zero
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        fill_next     = IDX_W'(1);
                        in_frame_next = 1'b1;
                        r_ok_next     = 1'b0;
                        m_ok_next     = 1'b0;
                        c_ok_next     = 1'b0;
                    end
                    else if (in_frame_reg)
                    begin
                        if (rx.rx_byte == nrmc_pkg::CH_CR || rx.rx_byte == nrmc_pkg::CH_LF)
                        begin
                            // terminator: close, start replay on a tag match
                            in_frame_next = 1'b0;
                            fill_next     = '0;
                            if (is_tag)
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = '0;
                                rd_idx_next   = '0;
                                last_idx_next = fill_reg - IDX_W'(1);
                                state_next    = nrmc_pkg::S_LOAD;
                            end
                        end
                        else if (rx.rx_byte inside
                                 {[nrmc_pkg::PRINT_LOW:nrmc_pkg::PRINT_HIGH]})
                        begin
                            if (fill_reg >= IDX_W'(BUFFER_BYTES - 1))
                            begin
                                // overflow drops the sentence
                                in_frame_next = 1'b0;
                                fill_next     = '0;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + IDX_W'(1);
                                if (fill_reg == IDX_W'(nrmc_pkg::POS_R))
                                begin
                                    r_ok_next = (rx.rx_byte == nrmc_pkg::CH_R);
                                end
                                if (fill_reg == IDX_W'(nrmc_pkg::POS_M))
                                begin
                                    m_ok_next = (rx.rx_byte == nrmc_pkg::CH_M);
                                end
                                if (fill_reg == IDX_W'(nrmc_pkg::POS_C))
                                begin
                                    c_ok_next = (rx.rx_byte == nrmc_pkg::CH_C);
                                end
                            end
                        end
                    end
                end
            end

            nrmc_pkg::S_LOAD:
            begin
                // read data is back: fill the output register
                out_valid_next = 1'b1;
                out_byte_next  = rd_data;
                out_last_next  = (rd_idx_reg == last_idx_reg);
                state_next     = nrmc_pkg::S_EMIT;
            end

            nrmc_pkg::S_EMIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = nrmc_pkg::S_COLLECT;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = rd_idx_reg + IDX_W'(1);
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = nrmc_pkg::S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next     = nrmc_pkg::S_COLLECT;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nrmc_pkg::S_COLLECT;
            in_frame_reg  <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_frame_reg  <= in_frame_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // tag flags, replay indexes and output payload
    always_ff @(posedge clk)
    begin
        r_ok_reg     <= r_ok_next;
        m_ok_reg     <= m_ok_next;
        c_ok_reg     <= c_ok_next;
        rd_idx_reg   <= rd_idx_next;
        last_idx_reg <= last_idx_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // terms for the checks below
    assign last_fire  = out_fire && out_last_reg;
    assign first_load = (state_reg == nrmc_pkg::S_LOAD) && (rd_idx_reg == '0);
    assign dollar_out = ({1'b0, sentence.sentence_byte} == nrmc_pkg::CH_DOLLAR);

    // input is never taken while a replayed character is pending
    `NRMC_ASSERT(a_no_overlap, clk, rst_n, !(rx.ready && sentence.valid), "rx ready in replay")

    // after the final character the framer takes bytes again
    `NRMC_ASSERT_NXT(a_back_to_collect, clk, rst_n, last_fire, rx.ready, "late return to collect")

    // every replay opens with the stored '$'
    `NRMC_ASSERT_NXT(a_starts_dollar, clk, rst_n, first_load, dollar_out, "no leading dollar")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUFFER_BYTES = 64;
    // time for the replay of a full buffer, plus margin
    localparam int SETTLE_CYCLES = 2 * BUFFER_BYTES + 20;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER_CHARS = 120;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 470;

    typedef struct {
        logic [7:0] data;
        bit         drain_first;
    } rx_item_t;

    typedef struct {
        logic [6:0] ch;
        logic       is_last;
    } sentence_char_t;

    logic clk = 1'b0;
    logic rst_n;

    nrmc_rx_if   rx_ch();
    nrmc_sent_if sent_ch();

    nmea_rmc_sentence_framer #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx_ch),
        .sentence (sent_ch)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bytes still to send, expected sentence characters
    rx_item_t       pending_rx[$];
    sentence_char_t sentence_expect_q[$];

    // predicted framer state
    logic       frame_open;
    logic [5:0] frame_fill;
    logic [6:0] frame_chars [BUFFER_BYTES];

    int  fail_count = 0;
    int  items_total = 0;
    int  items_accepted = 0;
    int  traffic_count = 0;
    bit  drain_next = 1'b0;
    int  rx_gap_left = 0;
    int  rx_calm_left = 0;
    int  out_stall_left = 0;
    int  out_calm_left = 0;
    int  quiet_cycles = 0;
    logic receiver_hold;
    int  hold_left = 0;
    int  chars_taken = 0;
    bit  hold_done = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // wait for the next transaction: zero in calm stretches, else 0..17
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm_left = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
    endfunction

    // framer prediction for one accepted byte
    task automatic frame_rx_byte(input logic [7:0] b);
        sentence_char_t c;
        if (b == nrmc_pkg::CH_DOLLAR)
        begin
            frame_chars[0] = b[6:0];
            frame_fill = 6'd1;
            frame_open = 1'b1;
        end
        else if (frame_open)
        begin
            if (b == nrmc_pkg::CH_CR || b == nrmc_pkg::CH_LF)
            begin
                if (frame_fill >= nrmc_pkg::MIN_RMC_LEN &&
                    {1'b0, frame_chars[0]} == nrmc_pkg::CH_DOLLAR &&
                    {1'b0, frame_chars[nrmc_pkg::POS_R]} == nrmc_pkg::CH_R &&
                    {1'b0, frame_chars[nrmc_pkg::POS_M]} == nrmc_pkg::CH_M &&
                    {1'b0, frame_chars[nrmc_pkg::POS_C]} == nrmc_pkg::CH_C)
                begin
                    for (int k = 0; k < frame_fill; k++)
                    begin
                        c.ch = frame_chars[k];
                        c.is_last = (k + 1 == frame_fill);
                        sentence_expect_q.push_back(c);
                    end
                end
                frame_fill = '0;
                frame_open = 1'b0;
            end
            else if (b >= nrmc_pkg::PRINT_LOW && b <= nrmc_pkg::PRINT_HIGH)
            begin
                // full buffer: the sentence is thrown away
                if (frame_fill == BUFFER_BYTES - 1)
                begin
                    frame_fill = '0;
                    frame_open = 1'b0;
                end
                else
                begin
                    frame_chars[frame_fill] = b[6:0];
                    frame_fill++;
                end
            end
        end
    endtask

    task automatic check_sentence_char(input logic [6:0] ch, input logic is_last);
        sentence_char_t want;
        if (sentence_expect_q.size() == 0)
        begin
            report_mismatch("unexpected sentence character", int'(ch), 0);
        end
        else
        begin
            want = sentence_expect_q.pop_front();
            if (ch !== want.ch)
                report_mismatch("sentence_byte", int'(ch), int'(want.ch));
            if (is_last !== want.is_last)
                report_mismatch("last_of_sentence", int'(is_last), int'(want.is_last));
        end
    endtask

    // stimulus building
    task automatic queue_byte(input logic [7:0] b);
        rx_item_t it;
        it.data = b;
        it.drain_first = drain_next;
        drain_next = 1'b0;
        pending_rx.push_back(it);
        traffic_count++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    function automatic logic [7:0] printable_char();
        logic [7:0] v;
        do
            v = 8'($urandom_range(nrmc_pkg::PRINT_LOW, nrmc_pkg::PRINT_HIGH));
        while (v == nrmc_pkg::CH_DOLLAR);
        return v;
    endfunction

    // control or high byte, never a terminator
    function automatic logic [7:0] junk_char();
        logic [7:0] v;
        if ($urandom_range(0, 1))
            return 8'($urandom_range(127, 255));
        do
            v = 8'($urandom_range(0, nrmc_pkg::PRINT_LOW - 1));
        while (v == nrmc_pkg::CH_CR || v == nrmc_pkg::CH_LF);
        return v;
    endfunction

    function automatic logic [7:0] terminator_char();
        return $urandom_range(0, 1) ? nrmc_pkg::CH_CR : nrmc_pkg::CH_LF;
    endfunction

    // '$', talker, tag, body, terminator, sometimes a trailing LF; a body over 57 overflows the buffer
    task automatic queue_sentence(input bit make_rmc, input int body_len, input bit with_junk);
        logic [7:0] tag [3];
        int bad;
        tag[0] = nrmc_pkg::CH_R;
        tag[1] = nrmc_pkg::CH_M;
        tag[2] = nrmc_pkg::CH_C;
        if (!make_rmc)
        begin
            bad = $urandom_range(0, 2);
            do
                tag[bad] = printable_char();
            while (tag[bad] == (bad == 0 ? nrmc_pkg::CH_R :
                                (bad == 1 ? nrmc_pkg::CH_M : nrmc_pkg::CH_C)));
        end
        queue_byte(nrmc_pkg::CH_DOLLAR);
        queue_byte(printable_char());
        queue_byte(printable_char());
        for (int i = 0; i < 3; i++)
            queue_byte(tag[i]);
        for (int i = 0; i < body_len; i++)
        begin
            if (with_junk && $urandom_range(0, 11) == 0)
                queue_byte(junk_char());
            queue_byte(printable_char());
        end
        queue_byte(terminator_char());
        if ($urandom_range(0, 3) == 0)
            queue_byte(nrmc_pkg::CH_LF);
    endtask

    function automatic int body_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 20);
        if (r < 95)
            return $urandom_range(21, 56);
        return 57;
    endfunction

    task automatic queue_random_traffic();
        rx_item_t it;
        int kind;
        int n;
        // full buffer and overflow once each, then the random mix
        drain_next = 1'b1;
        queue_sentence(1'b1, 57, 1'b0);
        queue_sentence(1'b1, 58 + $urandom_range(0, 3), 1'b1);
        while (traffic_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                drain_next = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                queue_sentence(1'b1, body_length(), 1'($urandom_range(0, 1)));
            end
            else if (kind < 65)
            begin
                queue_sentence(1'b0, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
            end
            else if (kind < 71)
            begin
                queue_sentence(1'b1, 58 + $urandom_range(0, 4), 1'b0);
            end
            else if (kind < 79)
            begin
                // short sentence, sometimes a tag that is cut off
                queue_byte(nrmc_pkg::CH_DOLLAR);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                    queue_byte(i >= 2 ? nrmc_pkg::CH_R : printable_char());
                queue_byte(terminator_char());
            end
            else if (kind < 88)
            begin
                // '$' restarts an open sentence
                queue_byte(nrmc_pkg::CH_DOLLAR);
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    queue_byte(printable_char());
                queue_sentence(1'b1, $urandom_range(0, 12), 1'b0);
            end
            else
            begin
                // line noise between sentences
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    it.data = 8'($urandom_range(0, 255));
                    it.drain_first = 1'b0;
                    pending_rx.push_back(it);
                    traffic_count++;
                end
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        rx_item_t nxt;
        logic offer_next;
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
            rx_ch.rx_byte <= '0;
            rx_gap_left = 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                frame_rx_byte(rx_ch.rx_byte);
                items_accepted++;
                rx_gap_left = draw_wait(rx_calm_left);
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                offer_next = 1'b0;
                if (rx_gap_left > 0)
                begin
                    rx_gap_left--;
                end
                else if (pending_rx.size() > 0 &&
                         !(pending_rx[0].drain_first && sentence_expect_q.size() != 0))
                begin
                    nxt = pending_rx.pop_front();
                    rx_ch.rx_byte <= nxt.data;
                    offer_next = 1'b1;
                end
                rx_ch.valid <= offer_next;
            end
        end
    end

    // long receiver hold-off once enough characters have come out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiver_hold <= 1'b0;
            hold_left = 0;
            chars_taken = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (sent_ch.valid && sent_ch.ready)
                chars_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                receiver_hold <= (hold_left != 0);
            end
            else if (!hold_done && chars_taken >= HOLD_AFTER_CHARS)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                receiver_hold <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        logic take_next;
        if (!rst_n)
        begin
            sent_ch.ready <= 1'b0;
            out_stall_left = 0;
        end
        else
        begin
            if (sent_ch.valid && sent_ch.ready)
            begin
                check_sentence_char(sent_ch.sentence_byte, sent_ch.last_of_sentence);
                out_stall_left = draw_wait(out_calm_left);
            end
            take_next = 1'b0;
            if (receiver_hold)
                take_next = 1'b0;
            else if (out_stall_left > 0)
                out_stall_left--;
            else
                take_next = 1'b1;
            sent_ch.ready <= take_next;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (sent_ch.valid && sent_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        sent_ch.ready = 1'b0;
        receiver_hold = 1'b0;
        frame_open = 1'b0;
        frame_fill = '0;
        rst_n = 1'b0;

        // directed: bytes outside a sentence, restart, dropped bytes,
        // printable extremes, RMC replay, short sentence, stray terminator
        queue_byte(nrmc_pkg::CH_CR);
        queue_byte(8'hFF);
        queue_text("A");
        queue_text("$GP");
        queue_text("$GPRMC");
        queue_byte(8'h00);
        queue_byte(8'h1F);
        queue_byte(8'h7F);
        queue_byte(8'h80);
        queue_byte(8'hFF);
        queue_text(" ~");
        queue_byte(nrmc_pkg::CH_CR);
        queue_text("$AB");
        queue_byte(nrmc_pkg::CH_LF);
        queue_byte(nrmc_pkg::CH_LF);

        queue_random_traffic();
        items_total = pending_rx.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < items_total)
            @(posedge clk);
        while (sentence_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
